// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the pattern matcher checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/cwpm_pkg.sv
// ----------------------------------------------------------------------------
// cwpm_pkg
// Types, constants and register codes of the caseless window pattern matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cwpm_pkg;

  localparam int MAX_PATTERN   = 20;
  localparam int MAX_COLUMN    = 4096;
  localparam int PATTERN_SLOTS = 20;
  localparam int PATTERN_LIM   = (MAX_PATTERN < PATTERN_SLOTS) ? MAX_PATTERN : PATTERN_SLOTS;

  localparam int CHAR_W   = 8;
  localparam int CODE_W   = 6;
  localparam int LINE_W   = 16;
  localparam int START_W  = 12;
  localparam int COL_W    = $clog2(MAX_COLUMN);
  localparam int HALF_W   = 60;
  localparam int LEN_W    = 5;
  localparam int EXCL_W   = 36;
  localparam int DATA_W   = 64;
  localparam int ADDR_W   = 5;
  localparam int REG_LSB  = 3;
  localparam int QDEPTH   = 2;

  typedef logic [CODE_W-1:0] code_t;
  typedef code_t [MAX_PATTERN-1:0] window_t;

  localparam code_t ALNUM_COUNT = code_t'(36);
  localparam code_t ALPHA_BASE  = code_t'(10);
  localparam code_t CODE_OTHER  = code_t'(36);
  localparam code_t CODE_DELIM  = code_t'(37);
  localparam code_t CODE_CLASS  = code_t'(63);

  localparam logic [COL_W-1:0]   COL_MAX   = COL_W'(MAX_COLUMN - 1);
  localparam logic [LINE_W-1:0]  LINE_MAX  = '1;
  localparam logic [LINE_W-1:0]  LINE_FIRST = LINE_W'(1);
  localparam logic [START_W-1:0] START_MAX = '1;
  localparam logic [LEN_W-1:0]   LEN_RESET = LEN_W'(1);

  typedef enum logic [1:0] {
    REG_PAT_LO = 2'd0,
    REG_PAT_HI = 2'd1,
    REG_LEN    = 2'd2,
    REG_EXCL   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [HALF_W-1:0] pat_lo;
    logic [HALF_W-1:0] pat_hi;
    logic [LEN_W-1:0]  length;
    logic [EXCL_W-1:0] excl;
  } cfg_t;

  typedef struct packed {
    window_t           window;
    logic [COL_W-1:0]  column;
    logic [LINE_W-1:0] line;
  } entry_t;

endpackage

// File: src/cwpm_if.sv
// ----------------------------------------------------------------------------
// cwpm interfaces
// Valid/ready channels for text words in and match words out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cwpm_text_if;
  logic                        valid;
  logic                        ready;
  logic [cwpm_pkg::CHAR_W-1:0] char_byte;
  logic                        line_break;

  modport source (output valid, output char_byte, output line_break, input ready);
  modport sink (input valid, input char_byte, input line_break, output ready);
endinterface

interface cwpm_match_if;
  logic                         valid;
  logic                         ready;
  logic [cwpm_pkg::LINE_W-1:0]  line_number;
  logic [cwpm_pkg::START_W-1:0] start_column;

  modport source (output valid, output line_number, output start_column, input ready);
  modport sink (input valid, input line_number, input start_column, output ready);
endinterface

// File: src/caseless_window_pattern_matcher.sv
// Path: an accepted text word is written into the word queue and popped from it into
// the output register, which raises any match word; a match-side stall can hold it back.
// Throughput: one text word per cycle while the queue is not full; the two-word queue
// and output register hold words while the match side stalls, and a full queue refuses text.
// Reset: synchronous; clears the window to delimiters, column to zero, line to one,
// the configuration to its defaults, the queue and the output valid.
// ----------------------------------------------------------------------------
// caseless_window_pattern_matcher
// Top level: APB registers, classifying front, word queue and compare back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module caseless_window_pattern_matcher (
  input  logic                        clk,
  input  logic                        rst,
  cwpm_text_if.sink                   text,
  cwpm_match_if.source                match,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cwpm_pkg::ADDR_W-1:0] paddr,
  input  logic [cwpm_pkg::DATA_W-1:0] pwdata,
  output logic [cwpm_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import cwpm_pkg::*;

  cfg_t   cfg;
  entry_t push_data;
  entry_t pop_data;
  logic   push;
  logic   pop;
  logic   full;
  logic   empty;

  cwpm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cwpm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .text      (text),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  cwpm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (full),
    .empty     (empty)
  );

  cwpm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .empty    (empty),
    .pop_data (pop_data),
    .pop      (pop),
    .match    (match)
  );

endmodule

// File: src/cwpm_regs.sv
// ----------------------------------------------------------------------------
// cwpm_regs
// APB configuration registers: pattern halves, pattern length, exclusion mask.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cwpm_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cwpm_pkg::ADDR_W-1:0] paddr,
  input  logic [cwpm_pkg::DATA_W-1:0] pwdata,
  output logic [cwpm_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output cwpm_pkg::cfg_t              cfg
);
  import cwpm_pkg::*;

  logic     wr;
  reg_idx_t reg_sel;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:REG_LSB]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pat_lo <= '0;
      cfg.pat_hi <= '0;
      cfg.length <= LEN_RESET;
      cfg.excl   <= '0;
    end else if (wr) begin
      unique case (reg_sel)
        REG_PAT_LO: cfg.pat_lo <= pwdata[HALF_W-1:0];
        REG_PAT_HI: cfg.pat_hi <= pwdata[HALF_W-1:0];
        REG_LEN:    cfg.length <= pwdata[LEN_W-1:0];
        REG_EXCL:   cfg.excl   <= pwdata[EXCL_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PAT_LO: prdata = DATA_W'(cfg.pat_lo);
      REG_PAT_HI: prdata = DATA_W'(cfg.pat_hi);
      REG_LEN:    prdata = DATA_W'(cfg.length);
      REG_EXCL:   prdata = DATA_W'(cfg.excl);
    endcase
  end

endmodule

// File: src/cwpm_front.sv
// ----------------------------------------------------------------------------
// cwpm_front
// Folds text bytes to case-free codes, shifts the window, counts columns
// and lines, and queues one word per text byte other than a line break for the compare stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cwpm_front (
  input  logic            clk,
  input  logic            rst,
  cwpm_text_if.sink       text,
  input  logic            full,
  output logic            push,
  output cwpm_pkg::entry_t push_data
);
  import cwpm_pkg::*;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CH_QUEST = 8'h3F;
  localparam logic [CHAR_W-1:0] CH_BANG  = 8'h21;
  localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_APOS  = 8'h27;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  function automatic code_t fold_byte(input logic [CHAR_W-1:0] b);
    code_t code;
    unique case (b) inside
      [CH_ZERO:CH_NINE]: code = code_t'(b - CH_ZERO);
      [CH_UP_A:CH_UP_Z]: code = code_t'(b - CH_UP_A) + ALPHA_BASE;
      [CH_LO_A:CH_LO_Z]: code = code_t'(b - CH_LO_A) + ALPHA_BASE;
      CH_DOT, CH_COMMA, CH_SEMI, CH_COLON, CH_QUEST, CH_BANG, CH_DQUOTE,
      CH_APOS, CH_SPACE: code = CODE_DELIM;
      default: code = CODE_OTHER;
    endcase
    return code;
  endfunction

  window_t           window;
  window_t           window_next;
  logic [COL_W-1:0]  column;
  logic [LINE_W-1:0] line;
  logic              accept;

  assign text.ready  = !full;
  assign accept      = text.valid && text.ready;
  assign push        = accept && !text.line_break;
  assign window_next = (window << CODE_W) | window_t'(fold_byte(text.char_byte));

  assign push_data.window = window_next;
  assign push_data.column = column;
  assign push_data.line   = line;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= {MAX_PATTERN{CODE_DELIM}};
      column <= '0;
      line   <= LINE_FIRST;
    end else if (accept) begin
      if (text.line_break) begin
        window <= {MAX_PATTERN{CODE_DELIM}};
        column <= '0;
        if (line != LINE_MAX) begin
          line <= line + LINE_W'(1);
        end
      end else begin
        window <= window_next;
        if (column != COL_MAX) begin
          column <= column + COL_W'(1);
        end
      end
    end
  end

endmodule

// File: src/cwpm_queue.sv
// ----------------------------------------------------------------------------
// cwpm_queue
// Short first-in first-out queue of window words between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cwpm_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cwpm_pkg::entry_t push_data,
  input  logic             pop,
  output cwpm_pkg::entry_t pop_data,
  output logic             full,
  output logic             empty
);
  import cwpm_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);

  entry_t           mem [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = count == CNT_W'(QDEPTH);
  assign empty    = count == '0;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: src/cwpm_back.sv
// ----------------------------------------------------------------------------
// cwpm_back
// Aligns the window to the pattern length, compares all slots in parallel
// and registers a match word with its line and start column.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cwpm_back (
  input  logic             clk,
  input  logic             rst,
  input  cwpm_pkg::cfg_t   cfg,
  input  logic             empty,
  input  cwpm_pkg::entry_t pop_data,
  output logic             pop,
  cwpm_match_if.source     match
);
  import cwpm_pkg::*;

  localparam int CODE_SPACE = 1 << CODE_W;
  localparam int COLX_W     = COL_W + 1;

  logic [LEN_W-1:0]            len;
  logic [LEN_W-1:0]            shamt;
  code_t [PATTERN_LIM-1:0]     rvec;
  code_t [PATTERN_LIM-1:0]     aligned;
  logic [2*HALF_W-1:0]         pattern;
  logic [CODE_SPACE-1:0]       excl_ext;
  logic [PATTERN_LIM-1:0]      slot_ok;
  logic                        hit;
  logic [COLX_W-1:0]           start_sum;
  logic [COL_W-1:0]            start_col;
  logic [31:0]                 start_wide;
  logic [START_W-1:0]          start;
  logic                        out_valid;
  logic [LINE_W-1:0]           out_line;
  logic [START_W-1:0]          out_start;
  logic                        advance;

  always_comb begin
    if (cfg.length == '0) begin
      len = LEN_W'(1);
    end else if (cfg.length > LEN_W'(PATTERN_LIM)) begin
      len = LEN_W'(PATTERN_LIM);
    end else begin
      len = cfg.length;
    end
  end

  assign shamt    = LEN_W'(PATTERN_LIM) - len;
  assign pattern  = {cfg.pat_hi, cfg.pat_lo};
  assign excl_ext = CODE_SPACE'(cfg.excl);

  always_comb begin
    for (int j = 0; j < PATTERN_LIM; j++) begin
      rvec[j] = pop_data.window[PATTERN_LIM-1-j];
    end
  end

  assign aligned = rvec >> (CODE_W * shamt);

  always_comb begin
    code_t w;
    code_t p;
    for (int i = 0; i < PATTERN_LIM; i++) begin
      w = aligned[i];
      p = pattern[CODE_W*i +: CODE_W];
      if (LEN_W'(i) >= len) begin
        slot_ok[i] = 1'b1;
      end else if (w == CODE_DELIM) begin
        slot_ok[i] = 1'b0;
      end else if (p == CODE_CLASS) begin
        slot_ok[i] = !excl_ext[w];
      end else begin
        slot_ok[i] = (p < ALNUM_COUNT) && (p == w);
      end
    end
  end

  assign hit = &slot_ok;

  assign start_sum  = {1'b0, pop_data.column} + COLX_W'(1) - COLX_W'(len);
  assign start_col  = (pop_data.column == COL_MAX) ? COL_MAX : start_sum[COL_W-1:0];
  assign start_wide = 32'(start_col);
  assign start      = (start_wide > 32'(START_MAX)) ? START_MAX : start_wide[START_W-1:0];

  assign advance = !out_valid || match.ready;
  assign pop     = !empty && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= pop && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_line  <= pop_data.line;
      out_start <= start;
    end
  end

  assign match.valid        = out_valid;
  assign match.line_number  = out_line;
  assign match.start_column = out_start;

endmodule

// File: src/cwpm_checker.sv
// ----------------------------------------------------------------------------
// cwpm_checker
// Port-level assertions for the pattern matcher, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cwpm_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         text_ready,
  input logic                         match_valid,
  input logic                         match_ready,
  input logic [cwpm_pkg::LINE_W-1:0]  line_number,
  input logic [cwpm_pkg::START_W-1:0] start_column,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [cwpm_pkg::ADDR_W-1:0]  paddr,
  input logic [cwpm_pkg::DATA_W-1:0]  pwdata,
  input logic [cwpm_pkg::DATA_W-1:0]  prdata
);
  import cwpm_pkg::*;

  logic                       excl_write;
  logic                       excl_addr;
  logic                       stalled;
  logic [LINE_W+START_W-1:0]  match_payload;
  logic [DATA_W-1:0]          excl_wdata_d;
  logic                       excl_read_ok;

  assign excl_addr     = paddr[ADDR_W-1:REG_LSB] == REG_EXCL;
  assign excl_write    = psel && penable && pwrite && excl_addr;
  assign stalled       = match_valid && !match_ready;
  assign match_payload = {line_number, start_column};
  assign excl_read_ok  = !excl_addr || (prdata == excl_wdata_d);

  always_ff @(posedge clk) begin
    excl_wdata_d <= DATA_W'(pwdata[EXCL_W-1:0]);
  end

  // A stalled match word stays offered.
  `ASSERT_NEXT(a_match_hold, clk, rst, stalled, match_valid, "match word dropped while stalled")

  // A stalled match word keeps its payload.
  `ASSERT_NEXT(a_match_stable, clk, rst, stalled, $stable(match_payload), "match payload changed")

  // Text is refused only when the queue is full, which needs a waiting match word.
  `ASSERT_SAME(a_backpressure, clk, rst, !text_ready, match_valid, "text refused, no match pending")

  // The exclusion mask reads back what was last written to it.
  `ASSERT_NEXT(a_excl_readback, clk, rst, excl_write, excl_read_ok, "exclusion mask read back wrong")

endmodule

bind caseless_window_pattern_matcher cwpm_checker u_cwpm_checker (
  .clk          (clk),
  .rst          (rst),
  .text_ready   (text.ready),
  .match_valid  (match.valid),
  .match_ready  (match.ready),
  .line_number  (match.line_number),
  .start_column (match.start_column),
  .psel         (psel),
  .penable      (penable),
  .pwrite       (pwrite),
  .paddr        (paddr),
  .pwdata       (pwdata),
  .prdata       (prdata)
);

// File: tb/cwpm_match_checker.sv
// ----------------------------------------------------------------------------
// cwpm_match_checker
// Watches the text, match and register channels of the pattern matcher. It
// keeps its own copy of the window, column, line and registers, predicts the
// match word, if any, of every accepted text word and compares each accepted
// match word with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cwpm_match_checker (
  input  logic                        clk,
  input  logic                        rst,
  cwpm_text_if                        text,
  cwpm_match_if                       match,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [cwpm_pkg::ADDR_W-1:0] paddr,
  input  logic [cwpm_pkg::DATA_W-1:0] pwdata,
  output int                          failures,
  output int                          outstanding
);
  import cwpm_pkg::*;

  typedef struct packed {
    logic [LINE_W-1:0]  line;
    logic [START_W-1:0] start;
  } match_word_t;

  match_word_t       expected_matches[$];
  logic [HALF_W-1:0] pat_lo;
  logic [HALF_W-1:0] pat_hi;
  logic [LEN_W-1:0]  pat_len;
  logic [EXCL_W-1:0] excl_mask;
  code_t             recent_codes[MAX_PATTERN];
  logic [COL_W-1:0]  column;
  logic [LINE_W-1:0] line;

  initial begin
    failures = 0;
    outstanding = 0;
  end

  function automatic code_t fold_char(logic [CHAR_W-1:0] b);
    if (b >= "0" && b <= "9") return code_t'(b - "0");
    if (b >= "A" && b <= "Z") return code_t'(b - "A") + ALPHA_BASE;
    if (b >= "a" && b <= "z") return code_t'(b - "a") + ALPHA_BASE;
    case (b)
      ".", ",", ";", ":", "?", "!", 8'h22, 8'h27, " ": return CODE_DELIM;
      default: return CODE_OTHER;
    endcase
  endfunction

  function automatic code_t pattern_slot(int i);
    logic [HALF_W-1:0] half;
    half = (i < 10) ? pat_lo : pat_hi;
    return half[CODE_W * (i % 10) +: CODE_W];
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    failures++;
  endtask

  task automatic scan_text_word(logic brk, logic [CHAR_W-1:0] b);
    int          len;
    int          col_before;
    int          start;
    logic        hit;
    code_t       w;
    code_t       p;
    match_word_t found;
    if (brk) begin
      foreach (recent_codes[i]) recent_codes[i] = CODE_DELIM;
      column = '0;
      if (line != LINE_MAX) line++;
      return;
    end
    for (int i = MAX_PATTERN - 1; i > 0; i--) recent_codes[i] = recent_codes[i-1];
    recent_codes[0] = fold_char(b);
    col_before = column;
    if (column != COL_MAX) column++;
    len = pat_len;
    if (len < 1) len = 1;
    if (len > PATTERN_LIM) len = PATTERN_LIM;
    hit = 1'b1;
    for (int i = 0; i < len; i++) begin
      w = recent_codes[len-1-i];
      p = pattern_slot(i);
      if (w == CODE_DELIM) begin
        hit = 1'b0;
      end else if (p == CODE_CLASS) begin
        if (w < ALNUM_COUNT && excl_mask[w]) hit = 1'b0;
      end else if (p >= ALNUM_COUNT || p != w) begin
        hit = 1'b0;
      end
    end
    if (!hit) return;
    start = (col_before >= MAX_COLUMN - 1) ? MAX_COLUMN - 1 : col_before + 1 - len;
    if (start > 4095) start = 4095;
    found.line = line;
    found.start = START_W'(start);
    expected_matches.insert(expected_matches.size(), found);
  endtask

  always @(posedge clk) begin
    match_word_t want;
    if (rst) begin
      pat_lo = '0;
      pat_hi = '0;
      pat_len = LEN_RESET;
      excl_mask = '0;
      foreach (recent_codes[i]) recent_codes[i] = CODE_DELIM;
      column = '0;
      line = LINE_FIRST;
      expected_matches.delete();
    end else begin
      if (match.valid && match.ready) begin
        if (expected_matches.size() == 0) begin
          report_mismatch($sformatf("unexpected match word line %0d column %0d",
                                    match.line_number, match.start_column));
        end else begin
          want = expected_matches.pop_front();
          if (match.line_number !== want.line)
            report_mismatch($sformatf("line_number %0h, expected %0h",
                                      match.line_number, want.line));
          if (match.start_column !== want.start)
            report_mismatch($sformatf("start_column %0h, expected %0h",
                                      match.start_column, want.start));
        end
      end
      if (text.valid && text.ready) scan_text_word(text.line_break, text.char_byte);
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[REG_LSB +: 2]))
          REG_PAT_LO: pat_lo = pwdata[HALF_W-1:0];
          REG_PAT_HI: pat_hi = pwdata[HALF_W-1:0];
          REG_LEN:    pat_len = pwdata[LEN_W-1:0];
          REG_EXCL:   excl_mask = pwdata[EXCL_W-1:0];
          default: ;
        endcase
      end
    end
    outstanding = expected_matches.size();
  end

endmodule

// File: tb/tb_caseless_window_pattern_matcher.sv
// ----------------------------------------------------------------------------
// tb_caseless_window_pattern_matcher
// Drives text words and register writes into the pattern matcher: a directed
// set of short lines, a stretch with the match side held off, and random
// phases of pattern-bearing text under many register settings. A checker
// instance predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_caseless_window_pattern_matcher;
  import cwpm_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                failures;
  int                outstanding;
  int                stall_cycles = 0;
  bit                quiet = 1'b0;
  bit                hold_request = 1'b0;

  code_t             pat_slot[PATTERN_SLOTS];
  int                cfg_len;
  int                eff_len;
  logic [EXCL_W-1:0] cfg_excl;

  cwpm_text_if  text_ch ();
  cwpm_match_if match_ch ();

  caseless_window_pattern_matcher dut (
    .clk     (clk),
    .rst     (rst),
    .text    (text_ch),
    .match   (match_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cwpm_match_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .text        (text_ch),
    .match       (match_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .failures    (failures),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (text_ch.valid && text_ch.ready) || (match_ch.valid && match_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_caseless_window_pattern_matcher failed");
        $finish;
      end
    end
  end

  initial begin
    forever begin
      if (hold_request) begin
        match_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        match_ch.ready <= quiet || ($urandom_range(99) >= 9);
        @(posedge clk);
      end
    end
  end

  task automatic apb_write(reg_idx_t idx, logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(int'(idx) << REG_LSB);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_matcher();
    logic [HALF_W-1:0] lo;
    logic [HALF_W-1:0] hi;
    logic [DATA_W-1:0] junk;
    for (int i = 0; i < 10; i++) begin
      lo[CODE_W*i +: CODE_W] = pat_slot[i];
      hi[CODE_W*i +: CODE_W] = pat_slot[10+i];
    end
    junk = {$urandom, $urandom};
    apb_write(REG_PAT_LO, {junk[DATA_W-1:HALF_W], lo});
    apb_write(REG_PAT_HI, {~junk[DATA_W-1:HALF_W], hi});
    apb_write(REG_LEN, {junk[DATA_W-1:LEN_W], LEN_W'(cfg_len)});
    apb_write(REG_EXCL, {junk[DATA_W-1:EXCL_W], cfg_excl});
    eff_len = (cfg_len < 1) ? 1 : (cfg_len > PATTERN_LIM) ? PATTERN_LIM : cfg_len;
  endtask

  task automatic send_text_word(logic brk, logic [CHAR_W-1:0] b);
    while (!quiet && $urandom_range(99) < 9) begin
      text_ch.valid <= 1'b0;
      @(posedge clk);
    end
    text_ch.valid <= 1'b1;
    text_ch.line_break <= brk;
    text_ch.char_byte <= b;
    do @(posedge clk); while (!text_ch.ready);
  endtask

  task automatic send_string(string s);
    for (int i = 0; i < s.len(); i++) send_text_word(1'b0, s[i]);
  endtask

  task automatic wait_idle();
    text_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CHAR_W-1:0] char_for_code(int c);
    if (c < 10) return CHAR_W'("0" + c);
    return $urandom_range(1) ? CHAR_W'("A" + c - 10) : CHAR_W'("a" + c - 10);
  endfunction

  function automatic logic [CHAR_W-1:0] delim_char();
    case ($urandom_range(8))
      0: return ".";
      1: return ",";
      2: return ";";
      3: return ":";
      4: return "?";
      5: return "!";
      6: return 8'h22;
      7: return 8'h27;
      default: return " ";
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] char_for_slot(int i);
    int k;
    if (pat_slot[i] < ALNUM_COUNT) return char_for_code(pat_slot[i]);
    if (pat_slot[i] != CODE_CLASS) return char_for_code($urandom_range(35));
    for (int t = 0; t < 4; t++) begin
      k = $urandom_range(35);
      if (!cfg_excl[k]) return char_for_code(k);
    end
    return CHAR_W'($urandom_range(128, 255));
  endfunction

  task automatic random_phase(int n_items, int len_pick, int extreme);
    int sent;
    int r;
    int bad_pos;
    r = $urandom_range(99);
    if (len_pick >= 0) cfg_len = len_pick;
    else if (r < 55) cfg_len = $urandom_range(1, 4);
    else if (r < 75) cfg_len = $urandom_range(5, 10);
    else if (r < 88) cfg_len = $urandom_range(11, 20);
    else if (r < 94) cfg_len = 0;
    else cfg_len = $urandom_range(21, 31);
    eff_len = (cfg_len < 1) ? 1 : (cfg_len > PATTERN_LIM) ? PATTERN_LIM : cfg_len;
    cfg_excl = EXCL_W'({$urandom, $urandom});
    if ($urandom_range(1)) cfg_excl &= EXCL_W'({$urandom, $urandom});
    for (int i = 0; i < PATTERN_SLOTS; i++) begin
      r = $urandom_range(99);
      if (i >= eff_len) pat_slot[i] = code_t'($urandom_range(63));
      else if (r < 75) pat_slot[i] = code_t'($urandom_range(35));
      else if (r < 95) pat_slot[i] = CODE_CLASS;
      else pat_slot[i] = code_t'($urandom_range(36, 62));
    end
    if (extreme == 1) begin
      foreach (pat_slot[i]) pat_slot[i] = CODE_CLASS;
      cfg_excl = '1;
    end else if (extreme == 2) begin
      foreach (pat_slot[i]) pat_slot[i] = '0;
      cfg_excl = '0;
    end
    program_matcher();
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 45) begin
        bad_pos = ($urandom_range(9) == 0) ? $urandom_range(eff_len - 1) : -1;
        for (int i = 0; i < eff_len; i++)
          send_text_word(1'b0, (i == bad_pos) ? CHAR_W'($urandom) : char_for_slot(i));
        sent += eff_len;
      end else begin
        if (r < 50) send_text_word(1'b1, CHAR_W'($urandom));
        else if (r < 72) send_text_word(1'b0, char_for_code($urandom_range(35)));
        else if (r < 82) send_text_word(1'b0, delim_char());
        else send_text_word(1'b0, CHAR_W'($urandom));
        sent++;
      end
    end
    wait_idle();
  endtask

  initial begin
    rst <= 1'b1;
    text_ch.valid <= 1'b0;
    text_ch.char_byte <= '0;
    text_ch.line_break <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (pat_slot[i]) pat_slot[i] = code_t'($urandom_range(63));
    pat_slot[0] = ALPHA_BASE;
    pat_slot[1] = CODE_CLASS;
    pat_slot[2] = code_t'(9);
    cfg_len = 3;
    cfg_excl = '0;
    cfg_excl[35] = 1'b1;
    cfg_excl[0] = 1'b1;
    program_matcher();
    send_string("aX9A~9");
    send_text_word(1'b1, 8'hFF);
    send_string("A9");
    send_text_word(1'b1, 8'h00);
    send_string("aZ9a09a.9");
    send_text_word(1'b1, 8'h5A);
    send_text_word(1'b0, 8'h00);
    send_text_word(1'b0, 8'hFF);
    wait_idle();

    foreach (pat_slot[i]) pat_slot[i] = CODE_CLASS;
    cfg_len = 1;
    cfg_excl = '0;
    program_matcher();
    hold_request = 1'b1;
    repeat (40) send_text_word(1'b0, char_for_code($urandom_range(35)));
    wait_idle();

    random_phase(90, 0, 0);
    random_phase(90, 20, 0);
    random_phase(90, 31, 1);
    random_phase(90, 2, 2);
    random_phase(90, -1, 0);
    quiet = 1'b1;
    random_phase(90, -1, 0);
    quiet = 1'b0;
    random_phase(90, -1, 0);
    random_phase(90, -1, 0);
    random_phase(90, -1, 0);

    if (failures == 0 && outstanding == 0) begin
      $display("tb_caseless_window_pattern_matcher passed");
    end else begin
      $display("tb_caseless_window_pattern_matcher failed");
    end
    $finish;
  end

endmodule
